// ===== hdl/pps_pkg.sv =====
package pps_pkg;

    localparam int PPS_MAX_PROCS = 16;

    localparam int ID_W    = 4;
    localparam int PRIO_W  = 8;
    localparam int WORK_W  = 16;
    localparam int TIME_W  = 32;
    localparam int STAT_W  = 3;

    // input command codes
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_IDLE   = 3'd0,
        ST_RAN    = 3'd1,
        ST_DONE   = 3'd2,
        ST_ACCEPT = 3'd3,
        ST_REJECT = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        ALU_SUB = 1'b0,
        ALU_GE  = 1'b1
    } t_alu_op;

    // one process slot as held in the slot memory
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [WORK_W-1:0] remaining;
        logic [WORK_W-1:0] burst;
        logic [TIME_W-1:0] arrival;
    } t_slot_rec;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   run_id;
        logic [WORK_W-1:0] left_after;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
    } t_result;

endpackage

// ===== hdl/pps_if.sv =====
interface pps_req_if;
    import pps_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [ID_W-1:0]   proc_id;
    logic [PRIO_W-1:0] prio;
    logic [WORK_W-1:0] burst;

    modport source (output valid, command, proc_id, prio, burst, input ready);
    modport sink   (input valid, command, proc_id, prio, burst, output ready);
endinterface

interface pps_rsp_if;
    import pps_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   run_id;
    logic [WORK_W-1:0] left_after;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;

    modport source (output valid, status, run_id, left_after, finish_time, turnaround,
                    waiting, input ready);
    modport sink   (input valid, status, run_id, left_after, finish_time, turnaround,
                    waiting, output ready);
endinterface

// ===== hdl/pps_slot_mem.sv =====
module pps_slot_mem #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  pps_pkg::t_slot_rec i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output pps_pkg::t_slot_rec o_rd_data
);
    import pps_pkg::*;

    t_slot_rec r_mem [DEPTH];
    t_slot_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/pps_alu.sv =====
module pps_alu (
    input  pps_pkg::t_alu_op          i_op,
    input  logic [pps_pkg::TIME_W-1:0] i_a,
    input  logic [pps_pkg::TIME_W-1:0] i_b,
    output logic [pps_pkg::TIME_W-1:0] o_y,
    output logic                      o_ge
);
    import pps_pkg::*;

    logic [TIME_W:0] diff;

    // one subtractor serves both the compare and the differences
    assign diff = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge = ~diff[TIME_W];

    always_comb begin
        unique case (i_op)
            ALU_SUB: o_y = diff[TIME_W-1:0];
            ALU_GE:  o_y = {{(TIME_W-1){1'b0}}, ~diff[TIME_W]};
            default: o_y = '0;
        endcase
    end

endmodule

// ===== hdl/preemptive_priority_scheduler.sv =====
// Channel  Dir  Protocol      Payload
// i_req    in   valid/ready   command, proc_id, prio, burst
// o_rsp    out  valid/ready   status, run_id, left_after, finish_time, turnaround, waiting
//
// Arrival request: accepted in idle, then loaded into the output register in S_OUT.
// Tick request: S_SCAN, S_LAST scan all slots, then S_OUT if none is ready; else S_FETCH,
//   S_DEC, then S_OUT if the winner keeps running or S_TAT, S_WAIT, S_OUT if it finishes.
//   The scan reads one slot per cycle through the slot memory's single read port.
// Reset clears the valid bits, the clock and the output valid; slot data is not cleared.
// i_req.ready is high only in idle; a result waiting in o_rsp stalls only the next load.
module preemptive_priority_scheduler #(
    parameter int MAX_PROCS = pps_pkg::PPS_MAX_PROCS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pps_req_if.sink   i_req,
    pps_rsp_if.source o_rsp
);
    import pps_pkg::*;

    localparam int SLOT_W = $clog2(MAX_PROCS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_PROCS - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_LAST  = 8'b0000_0100,
        S_FETCH = 8'b0000_1000,
        S_DEC   = 8'b0001_0000,
        S_TAT   = 8'b0010_0000,
        S_WAIT  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    // control state
    t_state                r_state, n_state;
    logic [MAX_PROCS-1:0]  r_valid, n_valid;
    logic [TIME_W-1:0]     r_time, n_time;
    logic                  r_out_valid, n_out_valid;

    // datapath registers
    logic [SLOT_W-1:0]     r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic [SLOT_W-1:0]     r_pend_idx, n_pend_idx;
    logic                  r_found, n_found;
    logic [SLOT_W-1:0]     r_best, n_best;
    logic [PRIO_W-1:0]     r_best_prio, n_best_prio;
    logic [TIME_W-1:0]     r_tat, n_tat;
    t_result               r_res, n_res;
    t_result               r_out, n_out;

    // slot memory and shared unit
    logic                  mem_wr_en;
    logic [SLOT_W-1:0]     mem_wr_addr;
    t_slot_rec             mem_wr_data;
    logic                  mem_rd_en;
    logic [SLOT_W-1:0]     mem_rd_addr;
    t_slot_rec             mem_rd_data;
    t_alu_op               alu_op;
    logic [TIME_W-1:0]     alu_a, alu_b, alu_y;
    logic                  alu_ge;

    logic                  in_fire;
    logic [SLOT_W-1:0]     in_slot;
    logic                  reject;
    logic                  take;
    logic [WORK_W-1:0]     left_next;

    pps_slot_mem #(.DEPTH(MAX_PROCS)) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (mem_wr_en),
        .i_wr_addr(mem_wr_addr),
        .i_wr_data(mem_wr_data),
        .i_rd_en  (mem_rd_en),
        .i_rd_addr(mem_rd_addr),
        .o_rd_data(mem_rd_data)
    );

    pps_alu u_alu (
        .i_op(alu_op),
        .i_a (alu_a),
        .i_b (alu_b),
        .o_y (alu_y),
        .o_ge(alu_ge)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign in_fire     = i_req.valid && (r_state == S_IDLE);
    assign in_slot     = SLOT_W'(i_req.proc_id);

    // slot beyond table, zero burst or occupied slot
    assign reject = (32'(i_req.proc_id) >= MAX_PROCS) || (i_req.burst == '0) ||
                    r_valid[in_slot];

    // scan: later slot wins ties, so >= against the best so far
    assign take = r_pend && r_valid[r_pend_idx] && (!r_found || alu_ge);

    assign left_next = alu_y[WORK_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_time      = r_time;
        n_out_valid = r_out_valid;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_found     = r_found;
        n_best      = r_best;
        n_best_prio = r_best_prio;
        n_tat       = r_tat;
        n_res       = r_res;
        n_out       = r_out;

        mem_wr_en   = 1'b0;
        mem_wr_addr = r_best;
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_idx;

        alu_op = ALU_GE;
        alu_a  = TIME_W'(mem_rd_data.prio);
        alu_b  = TIME_W'(r_best_prio);

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_req.command == CMD_TICK) begin
                        n_idx       = '0;
                        n_pend      = 1'b0;
                        n_found     = 1'b0;
                        n_best      = '0;
                        n_best_prio = '0;
                        n_state     = S_SCAN;
                    end else begin
                        n_res        = '0;
                        n_res.run_id = i_req.proc_id;
                        if (reject) begin
                            n_res.status = ST_REJECT;
                        end else begin
                            mem_wr_en             = 1'b1;
                            mem_wr_addr           = in_slot;
                            mem_wr_data.prio      = i_req.prio;
                            mem_wr_data.remaining = i_req.burst;
                            mem_wr_data.burst     = i_req.burst;
                            mem_wr_data.arrival   = r_time;
                            n_valid[in_slot]      = 1'b1;
                            n_res.status          = ST_ACCEPT;
                            n_res.left_after      = i_req.burst;
                        end
                        n_state = S_OUT;
                    end
                end
            end
            S_SCAN: begin
                // read slot r_idx while comparing the slot read last cycle
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_idx;
                if (take) begin
                    n_best      = r_pend_idx;
                    n_best_prio = mem_rd_data.prio;
                    n_found     = 1'b1;
                end
                n_pend     = 1'b1;
                n_pend_idx = r_idx;
                if (r_idx == LAST_SLOT) begin
                    n_state = S_LAST;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_LAST: begin
                n_time = r_time + TIME_W'(1);
                if (take) begin
                    n_best      = r_pend_idx;
                    n_best_prio = mem_rd_data.prio;
                    n_found     = 1'b1;
                end
                if (r_found || take) begin
                    n_state = S_FETCH;
                end else begin
                    n_res        = '0;
                    n_res.status = ST_IDLE;
                    n_state      = S_OUT;
                end
            end
            S_FETCH: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_best;
                n_state     = S_DEC;
            end
            S_DEC: begin
                alu_op = ALU_SUB;
                alu_a  = TIME_W'(mem_rd_data.remaining);
                alu_b  = TIME_W'(1);
                mem_wr_en             = 1'b1;
                mem_wr_addr           = r_best;
                mem_wr_data.remaining = left_next;
                n_res        = '0;
                n_res.run_id = ID_W'(r_best);
                if (left_next == '0) begin
                    n_valid[r_best] = 1'b0;
                    n_state         = S_TAT;
                end else begin
                    n_res.status     = ST_RAN;
                    n_res.left_after = left_next;
                    n_state          = S_OUT;
                end
            end
            S_TAT: begin
                alu_op  = ALU_SUB;
                alu_a   = r_time;
                alu_b   = mem_rd_data.arrival;
                n_tat   = alu_y;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                alu_op = ALU_SUB;
                alu_a  = r_tat;
                alu_b  = TIME_W'(mem_rd_data.burst);
                n_res.status      = ST_DONE;
                n_res.left_after  = '0;
                n_res.finish_time = r_time;
                n_res.turnaround  = r_tat;
                n_res.waiting     = alu_y;
                n_state           = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_time      <= n_time;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pend      <= n_pend;
        r_pend_idx  <= n_pend_idx;
        r_found     <= n_found;
        r_best      <= n_best;
        r_best_prio <= n_best_prio;
        r_tat       <= n_tat;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.run_id      = r_out.run_id;
    assign o_rsp.left_after  = r_out.left_after;
    assign o_rsp.finish_time = r_out.finish_time;
    assign o_rsp.turnaround  = r_out.turnaround;
    assign o_rsp.waiting     = r_out.waiting;

endmodule

// ===== hdl/pps_chk.sv =====
module pps_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [pps_pkg::STAT_W-1:0] i_out_status
);
    import pps_pkg::*;

    // no stale response survives reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    // ready is low in the cycle after a request is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after accept");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status <= ST_REJECT))
        else $error("undefined status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status))
        else $error("stalled response changed");

endmodule

bind preemptive_priority_scheduler pps_chk u_pps_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_status(o_rsp.status)
);

// ===== tb/sv/tb_preemptive_priority_scheduler.sv =====
import pps_pkg::*;

// One request as offered on the input channel.
typedef struct packed {
    logic              command;
    logic [ID_W-1:0]   proc_id;
    logic [PRIO_W-1:0] prio;
    logic [WORK_W-1:0] burst;
} sched_req_t;

// Scoreboard: keeps its own copy of the process table and the clock,
// predicts the outcome of every accepted request and checks the responses
// in order against it.
class sched_scoreboard;
    logic              slot_busy [PPS_MAX_PROCS];
    logic [PRIO_W-1:0] slot_level[PPS_MAX_PROCS];
    logic [WORK_W-1:0] slot_left [PPS_MAX_PROCS];
    logic [WORK_W-1:0] slot_len  [PPS_MAX_PROCS];
    logic [TIME_W-1:0] slot_born [PPS_MAX_PROCS];
    logic [TIME_W-1:0] clock_now;
    t_result           pending_outcomes[$];
    int                errors;

    function new();
        for (int i = 0; i < PPS_MAX_PROCS; i++) begin
            slot_busy[i]  = 1'b0;
            slot_level[i] = '0;
            slot_left[i]  = '0;
            slot_len[i]   = '0;
            slot_born[i]  = '0;
        end
        clock_now = '0;
        errors    = 0;
    endfunction

    // Returns a random slot whose busy flag equals want_busy, or -1 if none.
    function int pick_slot(logic want_busy);
        int hits[$];
        for (int i = 0; i < PPS_MAX_PROCS; i++)
            if (slot_busy[i] == want_busy)
                hits.insert(hits.size(), i);
        if (hits.size() == 0)
            return -1;
        return hits[$urandom_range(hits.size() - 1)];
    endfunction

    // Accepted request: update the table and queue the outcome it causes.
    function void log_request(sched_req_t r);
        t_result e;
        logic    found;
        int      best;
        e = '0;
        if (r.command == CMD_ARRIVE) begin
            e.run_id = r.proc_id;
            if (int'(r.proc_id) >= PPS_MAX_PROCS || r.burst == '0 || slot_busy[r.proc_id]) begin
                e.status = ST_REJECT;
            end else begin
                slot_busy[r.proc_id]  = 1'b1;
                slot_level[r.proc_id] = r.prio;
                slot_left[r.proc_id]  = r.burst;
                slot_len[r.proc_id]   = r.burst;
                slot_born[r.proc_id]  = clock_now;
                e.status     = ST_ACCEPT;
                e.left_after = r.burst;
            end
        end else begin
            found = 1'b0;
            best  = 0;
            // >= lets the later (higher) slot win a tie
            for (int i = 0; i < PPS_MAX_PROCS; i++) begin
                if (slot_busy[i] && (!found || slot_level[i] >= slot_level[best])) begin
                    best  = i;
                    found = 1'b1;
                end
            end
            clock_now = clock_now + TIME_W'(1);
            if (!found) begin
                e.status = ST_IDLE;
            end else begin
                slot_left[best] = slot_left[best] - WORK_W'(1);
                e.run_id = best[ID_W-1:0];
                if (slot_left[best] == '0) begin
                    slot_busy[best] = 1'b0;
                    e.status        = ST_DONE;
                    e.finish_time   = clock_now;
                    e.turnaround    = clock_now - slot_born[best];
                    e.waiting       = e.turnaround - TIME_W'(slot_len[best]);
                end else begin
                    e.status     = ST_RAN;
                    e.left_after = slot_left[best];
                end
            end
        end
        pending_outcomes.insert(pending_outcomes.size(), e);
    endfunction

    task report(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task check_result(t_result got);
        t_result want;
        if (pending_outcomes.size() == 0) begin
            report($sformatf("response with nothing outstanding, status %0d", got.status));
            return;
        end
        want = pending_outcomes.pop_front();
        if (got.status !== want.status)
            report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.run_id !== want.run_id)
            report($sformatf("run_id got %0d want %0d", got.run_id, want.run_id));
        if (got.left_after !== want.left_after)
            report($sformatf("left_after got %0d want %0d", got.left_after, want.left_after));
        if (got.finish_time !== want.finish_time)
            report($sformatf("finish_time got %0d want %0d", got.finish_time, want.finish_time));
        if (got.turnaround !== want.turnaround)
            report($sformatf("turnaround got %0d want %0d", got.turnaround, want.turnaround));
        if (got.waiting !== want.waiting)
            report($sformatf("waiting got %0d want %0d", got.waiting, want.waiting));
    endtask
endclass

module tb_preemptive_priority_scheduler;

    // Worst case per request is the longest tick in the block plus handshake gaps on
    // both sides at up to 68% idle, plus one long sink hold-off. This limit is
    // several times that for ~1320 requests.
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 400;    // response count that starts the hold-off
    localparam int HOLD_LEN    = 600;    // cycles the sink holds ready low
    localparam int DRAIN_WAIT  = 40;     // settle time after the last response

    logic i_clk;
    logic i_rst_n;

    pps_req_if req_ch();
    pps_rsp_if rsp_ch();

    preemptive_priority_scheduler u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    sched_scoreboard sched_sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    int results_seen = 0;
    int hold_left    = 0;
    int cycle_count  = 0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Response sink. Samples the handshake with pre-edge values, then picks
    // ready for the next cycle. After HOLD_AT responses it holds ready low until
    // the HOLD_LEN count in hold_left runs out, so the block backs up and stalls its request side.
    always @(posedge i_clk) begin : rsp_sink
        t_result got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.status      = t_status'(rsp_ch.status);
            got.run_id      = rsp_ch.run_id;
            got.left_after  = rsp_ch.left_after;
            got.finish_time = rsp_ch.finish_time;
            got.turnaround  = rsp_ch.turnaround;
            got.waiting     = rsp_ch.waiting;
            sched_sb.check_result(got);
            results_seen++;
            if (results_seen == HOLD_AT)
                hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one request and wait for it to be taken. Idle cycles come before
    // the request; valid stays high across back-to-back requests.
    task send_request(logic cmd, logic [ID_W-1:0] id, logic [PRIO_W-1:0] level,
                      logic [WORK_W-1:0] work);
        sched_req_t r;
        r.command = cmd;
        r.proc_id = id;
        r.prio    = level;
        r.burst   = work;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= r.command;
        req_ch.proc_id <= r.proc_id;
        req_ch.prio    <= r.prio;
        req_ch.burst   <= r.burst;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        sched_sb.log_request(r);
    endtask

    task send_tick();
        // payload is ignored on a tick; randomize it anyway
        send_request(CMD_TICK, ID_W'($urandom_range(15)), PRIO_W'($urandom_range(255)),
                     WORK_W'($urandom_range(65535)));
    endtask

    // Random traffic: mostly ticks and well-formed arrivals into free slots
    // with short bursts, so processes keep finishing; the rest are arrivals
    // onto busy slots with full-range payload, and zero-burst arrivals.
    task drive_random(int count);
        int                pick;
        int                slot;
        logic [PRIO_W-1:0] level;
        logic [WORK_W-1:0] work;
        for (int n = 0; n < count; n++) begin
            pick = int'($urandom_range(99));
            if (pick < 62) begin
                send_tick();
            end else if (pick < 90) begin
                slot = sched_sb.pick_slot(1'b0);
                if (slot < 0)
                    slot = int'($urandom_range(15));
                // half the time a narrow priority range, to force ties
                level = $urandom_range(1) ? PRIO_W'($urandom_range(255)) :
                                            PRIO_W'($urandom_range(3));
                work  = ($urandom_range(19) == 0) ? WORK_W'($urandom_range(1, 30)) :
                                                    WORK_W'($urandom_range(1, 3));
                send_request(CMD_ARRIVE, ID_W'(slot), level, work);
            end else if (pick < 97) begin
                // occupied slot: rejected, so any burst is safe here
                slot = sched_sb.pick_slot(1'b1);
                if (slot < 0)
                    send_request(CMD_ARRIVE, ID_W'($urandom_range(15)),
                                 PRIO_W'($urandom_range(255)), '0);
                else
                    send_request(CMD_ARRIVE, ID_W'(slot), PRIO_W'($urandom_range(255)),
                                 WORK_W'($urandom_range(65535)));
            end else begin
                send_request(CMD_ARRIVE, ID_W'($urandom_range(15)),
                             PRIO_W'($urandom_range(255)), '0);
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.command = CMD_ARRIVE;
        req_ch.proc_id = '0;
        req_ch.prio    = '0;
        req_ch.burst   = '0;
        send_idle_pct  = 33;
        recv_idle_pct  = 68;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        send_tick();                                    // idle tick, empty table
        // slot 0 gets a huge low-priority job; it only runs when nothing else is
        // ready and loses every tie, so it never finishes during the run
        send_request(CMD_ARRIVE, 4'd0,  8'd0,   16'hFFFF);
        send_request(CMD_ARRIVE, 4'd0,  8'd255, 16'd1);    // occupied slot
        send_request(CMD_ARRIVE, 4'd15, 8'd255, 16'd0);    // zero burst
        send_request(CMD_ARRIVE, 4'd15, 8'd255, 16'd1);
        send_request(CMD_ARRIVE, 4'd7,  8'd255, 16'd2);    // ties slot 15
        send_request(CMD_ARRIVE, 4'd3,  8'd0,   16'd3);    // ties slot 0
        send_request(CMD_ARRIVE, 4'd0,  8'h55,  16'hAAAA); // occupied, alt bits
        send_request(CMD_ARRIVE, 4'd0,  8'hAA,  16'h5555); // occupied, alt bits
        send_tick();                                    // 15 wins tie, finishes
        send_tick();                                    // 7 runs
        send_tick();                                    // 7 finishes
        send_tick();                                    // 3 beats 0 on tie
        send_tick();
        send_tick();                                    // 3 finishes
        send_tick();                                    // only slot 0 left: runs
        send_request(CMD_ARRIVE, 4'd15, 8'd1, 16'd2);
        send_request(CMD_ARRIVE, 4'd8,  8'd2, 16'd1);
        send_tick();                                    // 8 finishes first
        send_tick();
        send_tick();                                    // 15 finishes, waited one tick

        // Random part in three idling phases.
        drive_random(430);
        send_idle_pct = 68;
        recv_idle_pct = 33;
        drive_random(430);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        drive_random(440);
        req_ch.valid <= 1'b0;

        // Drain: the watchdog catches a response that never shows up.
        while (sched_sb.pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sched_sb.errors == 0 && sched_sb.pending_outcomes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pps_pkg.sv
hdl/pps_if.sv
hdl/pps_slot_mem.sv
hdl/pps_alu.sv
hdl/preemptive_priority_scheduler.sv
hdl/pps_chk.sv
tb/sv/tb_preemptive_priority_scheduler.sv
